### rtl/fhw_pkg.sv
package fhw_pkg;

	localparam logic [2:0] OP_FRAME_START  = 3'd0;
	localparam logic [2:0] OP_FRAME_END    = 3'd1;
	localparam logic [2:0] OP_RECORD_PHASE = 3'd2;
	localparam logic [2:0] OP_GATED_WORK   = 3'd3;
	localparam logic [2:0] OP_WD_TICK      = 3'd4;

	localparam logic [1:0] PAINT_NONE  = 2'd0;
	localparam logic [1:0] PAINT_ALIVE = 2'd1;
	localparam logic [1:0] PAINT_STALE = 2'd2;

	localparam logic [15:0] COLOR_RED   = 16'hF801;
	localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
	localparam logic [15:0] COLOR_BLACK = 16'h0001;

	localparam logic [2:0] REG_HUNG_FRAME_LIMIT   = 3'd0;
	localparam logic [2:0] REG_PERF_WINDOW_FRAMES = 3'd1;
	localparam logic [2:0] REG_STALE_TICK_LIMIT   = 3'd2;
	localparam logic [2:0] REG_DONE_PHASE_COLOR   = 3'd3;
	localparam logic [2:0] REG_OVERLAY_ENABLE     = 3'd4;

	localparam logic [9:0] STREAK_MAX = 10'd1023;
	localparam logic [7:0] STALE_MAX  = 8'd255;

	typedef struct packed {
		logic [2:0]  operation;
		logic        pending_gfx;
		logic [31:0] time_usec;
		logic [31:0] work_usec;
		logic [15:0] phase_color;
		logic        fault_pending;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  paint_action;
		logic [15:0] top_color;
		logic [15:0] band_color;
		logic        write_report;
		logic [31:0] worst_frame_usec;
		logic [31:0] worst_gated_usec;
		logic        task_hung;
		logic        cpu_faulted;
		logic [31:0] heartbeat_count;
		logic [15:0] current_phase;
		logic        overlay_shown;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  hung_frame_limit;
		logic [9:0]  perf_window_frames;
		logic [7:0]  stale_tick_limit;
		logic [15:0] done_phase_color;
		logic        overlay_enable;
	} cfg_t;

endpackage

### rtl/fhw_stream_if.sv
interface fhw_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/frame_health_watchdog_top.sv
// Frame health watchdog. Each event item on evt yields exactly one result item on rsp,
// in order. An item is captured in an input register, evaluated against the monitor
// state combinationally, and the result is held in an output register until taken, so
// the block takes one item per cycle unless the output register is full and not taken;
// a result is offered once its item has moved from the input to the output register.
// The only stall is a full output register that the sink has not taken.
// Registers are to be written via cfg_we, cfg_index and cfg_data only while no item is
// in flight; the block does not enforce this. Indexes beyond the list are ignored.
module frame_health_watchdog_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fhw_stream_if.sink   evt,
	fhw_stream_if.source rsp
);
	import fhw_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      adv;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign evt.ready = !valid_s1 || adv;
	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hung_frame_limit   <= 10'd120;
			cfg_q.perf_window_frames <= 10'd120;
			cfg_q.stale_tick_limit   <= 8'd2;
			cfg_q.done_phase_color   <= 16'd63;
			cfg_q.overlay_enable     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUNG_FRAME_LIMIT:   cfg_q.hung_frame_limit   <= cfg_data[9:0];
				REG_PERF_WINDOW_FRAMES: cfg_q.perf_window_frames <= cfg_data[9:0];
				REG_STALE_TICK_LIMIT:   cfg_q.stale_tick_limit   <= cfg_data[7:0];
				REG_DONE_PHASE_COLOR:   cfg_q.done_phase_color   <= cfg_data;
				REG_OVERLAY_ENABLE:     cfg_q.overlay_enable     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (evt.valid && evt.ready) valid_s1 <= 1'b1;
			else if (adv)               valid_s1 <= 1'b0;
			if (adv)            valid_s2 <= 1'b1;
			else if (rsp.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) item_s1 <= evt.data;
		if (adv)                    res_s2  <= res;
	end

	fhw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// The report request only ever comes with a stale paint.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.write_report |-> rsp.data.paint_action == PAINT_STALE)
		else $error("report request without stale paint");

	// Without a paint both colors read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.paint_action == PAINT_NONE
		|-> rsp.data.top_color == 16'd0 && rsp.data.band_color == 16'd0)
		else $error("colors set without paint");

	// Input side stalls only behind a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> rsp.valid && !rsp.ready)
		else $error("input stalled while output free");
endmodule

### rtl/fhw_core.sv
module fhw_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  fhw_pkg::in_item_t item,
	input  fhw_pkg::cfg_t     cfg,
	output fhw_pkg::out_item_t res
);
	import fhw_pkg::*;

	logic [31:0] heartbeat_q, heartbeat_n;
	logic        beat_q, beat_n;
	logic [7:0]  stale_q, stale_n;
	logic        report_done_q, report_done_n;
	logic        fault_q, fault_n;
	logic        hung_q, hung_n;
	logic [9:0]  streak_q, streak_n;
	logic [9:0]  window_q, window_n;
	logic [31:0] worst_frame_q, worst_frame_n;
	logic [31:0] worst_gated_q, worst_gated_n;
	logic [31:0] last_time_q, last_time_n;
	logic        last_valid_q, last_valid_n;
	logic [15:0] phase_q, phase_n;

	logic [31:0] interval;
	logic [15:0] rec_color;

	always_comb begin
		heartbeat_n   = heartbeat_q;
		beat_n        = beat_q;
		stale_n       = stale_q;
		report_done_n = report_done_q;
		fault_n       = fault_q;
		hung_n        = hung_q;
		streak_n      = streak_q;
		window_n      = window_q;
		worst_frame_n = worst_frame_q;
		worst_gated_n = worst_gated_q;
		last_time_n   = last_time_q;
		last_valid_n  = last_valid_q;
		phase_n       = phase_q;

		res              = '0;
		interval         = item.time_usec - last_time_q;
		rec_color        = (item.operation == OP_FRAME_END) ? cfg.done_phase_color
		                                                    : item.phase_color;

		case (item.operation)
			OP_FRAME_START: begin
				heartbeat_n = heartbeat_q + 32'd1;
				beat_n      = 1'b1;
				if (!item.pending_gfx) begin
					streak_n = '0;
				end else begin
					if (streak_q != STREAK_MAX) streak_n = streak_q + 10'd1;
					if (streak_n > cfg.hung_frame_limit && !hung_q) begin
						hung_n           = 1'b1;
						res.paint_action = PAINT_STALE;
						res.top_color    = COLOR_RED;
						res.band_color   = fault_q ? COLOR_WHITE : COLOR_BLACK;
					end
				end
				if (last_valid_q) begin
					if (interval > worst_frame_q) worst_frame_n = interval;
					window_n = window_q + 10'd1;
					if (window_n >= cfg.perf_window_frames) begin
						window_n      = '0;
						worst_frame_n = interval;
						worst_gated_n = '0;
					end
				end
				last_time_n  = item.time_usec;
				last_valid_n = 1'b1;
			end
			OP_FRAME_END, OP_RECORD_PHASE: begin
				phase_n = rec_color;
				if (!hung_q && cfg.overlay_enable) begin
					res.paint_action = PAINT_ALIVE;
					res.top_color    = rec_color;
					res.band_color   = rec_color;
				end
			end
			OP_GATED_WORK: begin
				if (item.work_usec > worst_gated_q) worst_gated_n = item.work_usec;
			end
			OP_WD_TICK: begin
				fault_n = fault_q | item.fault_pending;
				if (beat_q) begin
					beat_n  = 1'b0;
					stale_n = '0;
				end else begin
					if (stale_q != STALE_MAX) stale_n = stale_q + 8'd1;
					if (stale_n >= cfg.stale_tick_limit) begin
						res.paint_action = PAINT_STALE;
						res.top_color    = hung_q ? COLOR_RED : phase_q;
						res.band_color   = fault_n ? COLOR_WHITE : COLOR_BLACK;
						if (!report_done_q) begin
							report_done_n    = 1'b1;
							res.write_report = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		res.worst_frame_usec = worst_frame_n;
		res.worst_gated_usec = worst_gated_n;
		res.task_hung        = hung_n;
		res.cpu_faulted      = fault_n;
		res.heartbeat_count  = heartbeat_n;
		res.current_phase    = phase_n;
		res.overlay_shown    = cfg.overlay_enable | hung_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heartbeat_q   <= '0;
			beat_q        <= 1'b0;
			stale_q       <= '0;
			report_done_q <= 1'b0;
			fault_q       <= 1'b0;
			hung_q        <= 1'b0;
			streak_q      <= '0;
			window_q      <= '0;
			worst_frame_q <= '0;
			worst_gated_q <= '0;
			last_time_q   <= '0;
			last_valid_q  <= 1'b0;
			phase_q       <= '0;
		end else if (en) begin
			heartbeat_q   <= heartbeat_n;
			beat_q        <= beat_n;
			stale_q       <= stale_n;
			report_done_q <= report_done_n;
			fault_q       <= fault_n;
			hung_q        <= hung_n;
			streak_q      <= streak_n;
			window_q      <= window_n;
			worst_frame_q <= worst_frame_n;
			worst_gated_q <= worst_gated_n;
			last_time_q   <= last_time_n;
			last_valid_q  <= last_valid_n;
			phase_q       <= phase_n;
		end
	end
endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fhw_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	fhw_stream_if #(.T(in_item_t))  evt_if ();
	fhw_stream_if #(.T(out_item_t)) rsp_if ();

	frame_health_watchdog_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt_if.sink),
		.rsp       (rsp_if.source)
	);

	// Register copies kept by the predictor.
	logic [9:0]  c_hung_limit;
	logic [9:0]  c_window;
	logic [7:0]  c_stale_limit;
	logic [15:0] c_done_color;
	logic        c_overlay;

	// Monitor state kept by the predictor.
	logic [31:0] m_heartbeat;
	logic        m_beat;
	logic [7:0]  m_stale;
	logic        m_report_done;
	logic        m_fault;
	logic        m_hung;
	logic [9:0]  m_streak;
	logic [9:0]  m_window;
	logic [31:0] m_worst_frame;
	logic [31:0] m_worst_gated;
	logic [31:0] m_last_time;
	logic        m_time_valid;
	logic [15:0] m_phase;

	out_item_t   status_due[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	logic [31:0] frame_clock = 32'd0;
	bit          allow_fault = 1'b0;
	bit          tx_gaps_on = 1'b1;
	int          tx_burst_left = 0;
	int          rx_hold_req = 0;
	int          rx_hold_left = 0;
	int          rx_mode = 0;
	int          rx_mode_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void reset_model();
		c_hung_limit  = 10'd120;
		c_window      = 10'd120;
		c_stale_limit = 8'd2;
		c_done_color  = 16'd63;
		c_overlay     = 1'b0;
		m_heartbeat   = '0;
		m_beat        = 1'b0;
		m_stale       = '0;
		m_report_done = 1'b0;
		m_fault       = 1'b0;
		m_hung        = 1'b0;
		m_streak      = '0;
		m_window      = '0;
		m_worst_frame = '0;
		m_worst_gated = '0;
		m_last_time   = '0;
		m_time_valid  = 1'b0;
		m_phase       = '0;
	endfunction

	// Advances the monitor copy by one event and returns the status it reports.
	function automatic out_item_t watchdog_step(input in_item_t it);
		out_item_t   r;
		logic        stale;
		logic        alive;
		logic [31:0] gap;
		r     = '0;
		stale = 1'b0;
		alive = 1'b0;
		case (it.operation)
			OP_FRAME_START: begin
				m_heartbeat = m_heartbeat + 32'd1;
				m_beat = 1'b1;
				if (!it.pending_gfx) begin
					m_streak = '0;
				end else begin
					if (m_streak < STREAK_MAX)
						m_streak = m_streak + 10'd1;
					if (m_streak > c_hung_limit && !m_hung) begin
						m_hung = 1'b1;
						stale = 1'b1;
					end
				end
				if (m_time_valid) begin
					gap = it.time_usec - m_last_time;
					if (gap > m_worst_frame)
						m_worst_frame = gap;
					m_window = m_window + 10'd1;
					if (m_window >= c_window) begin
						m_window = '0;
						m_worst_frame = gap;
						m_worst_gated = '0;
					end
				end
				m_last_time = it.time_usec;
				m_time_valid = 1'b1;
			end
			OP_FRAME_END, OP_RECORD_PHASE: begin
				m_phase = (it.operation == OP_FRAME_END) ? c_done_color : it.phase_color;
				alive = !m_hung && c_overlay;
			end
			OP_GATED_WORK: begin
				if (it.work_usec > m_worst_gated)
					m_worst_gated = it.work_usec;
			end
			OP_WD_TICK: begin
				if (it.fault_pending)
					m_fault = 1'b1;
				if (m_beat) begin
					m_beat = 1'b0;
					m_stale = '0;
				end else begin
					if (m_stale < STALE_MAX)
						m_stale = m_stale + 8'd1;
					if (m_stale >= c_stale_limit) begin
						stale = 1'b1;
						if (!m_report_done) begin
							m_report_done = 1'b1;
							r.write_report = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		// The colors depend only on latches and the phase, none of which change
		// after the paint is ordered within one event.
		if (stale) begin
			r.paint_action = PAINT_STALE;
			r.top_color = m_hung ? COLOR_RED : m_phase;
			r.band_color = m_fault ? COLOR_WHITE : COLOR_BLACK;
		end else if (alive) begin
			r.paint_action = PAINT_ALIVE;
			r.top_color = m_phase;
			r.band_color = m_phase;
		end
		r.worst_frame_usec = m_worst_frame;
		r.worst_gated_usec = m_worst_gated;
		r.task_hung = m_hung;
		r.cpu_faulted = m_fault;
		r.heartbeat_count = m_heartbeat;
		r.current_phase = m_phase;
		r.overlay_shown = c_overlay | m_hung;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : status_check
		out_item_t want;
		out_item_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (status_due.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				check_field("paint_action", 32'(want.paint_action), 32'(got.paint_action));
				check_field("top_color", 32'(want.top_color), 32'(got.top_color));
				check_field("band_color", 32'(want.band_color), 32'(got.band_color));
				check_field("write_report", 32'(want.write_report), 32'(got.write_report));
				check_field("worst_frame_usec", want.worst_frame_usec, got.worst_frame_usec);
				check_field("worst_gated_usec", want.worst_gated_usec, got.worst_gated_usec);
				check_field("task_hung", 32'(want.task_hung), 32'(got.task_hung));
				check_field("cpu_faulted", 32'(want.cpu_faulted), 32'(got.cpu_faulted));
				check_field("heartbeat_count", want.heartbeat_count, got.heartbeat_count);
				check_field("current_phase", 32'(want.current_phase),
					32'(got.current_phase));
				check_field("overlay_shown", 32'(want.overlay_shown),
					32'(got.overlay_shown));
			end
		end
	end

	// Receiver: segments of steady, light or heavy stalling, plus a long hold on request.
	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(8, 80);
		end else begin
			rx_mode_left--;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
				default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	function automatic in_item_t make_item(input logic [2:0] op);
		in_item_t it;
		it.operation = op;
		it.pending_gfx = 1'($urandom_range(0, 1));
		it.time_usec = $urandom;
		it.work_usec = $urandom;
		it.phase_color = 16'($urandom_range(0, 65535));
		it.fault_pending = allow_fault ? 1'($urandom_range(0, 1)) : 1'b0;
		return it;
	endfunction

	task automatic send_event(input in_item_t it);
		evt_if.valid <= 1'b1;
		evt_if.data <= it;
		@(posedge clk);
		while (!evt_if.ready)
			@(posedge clk);
		status_due.push_back(watchdog_step(it));
		items_sent++;
		if (tx_gaps_on) begin
			if (tx_burst_left > 0) begin
				tx_burst_left--;
			end else begin
				evt_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				tx_burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
			end
		end
	endtask

	// Stops offering items and waits until every result has been taken.
	task automatic drain();
		evt_if.valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_HUNG_FRAME_LIMIT:   c_hung_limit = val[9:0];
			REG_PERF_WINDOW_FRAMES: c_window = val[9:0];
			REG_STALE_TICK_LIMIT:   c_stale_limit = val[7:0];
			REG_DONE_PHASE_COLOR:   c_done_color = val;
			REG_OVERLAY_ENABLE:     c_overlay = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic send_frame_start(input logic pending, input logic [31:0] stamp);
		in_item_t it;
		it = make_item(OP_FRAME_START);
		it.pending_gfx = pending;
		it.time_usec = stamp;
		send_event(it);
	endtask

	// One frame with random content, or now and then a stray item of any code.
	task automatic play_frame();
		in_item_t it;
		int       n;
		if ($urandom_range(0, 99) < 15) begin
			send_event(make_item(3'($urandom_range(0, 7))));
			return;
		end
		frame_clock = frame_clock + $urandom_range(1, 40000);
		if ($urandom_range(0, 49) == 0)
			frame_clock = $urandom;
		send_frame_start($urandom_range(0, 2) == 0, frame_clock);
		n = $urandom_range(0, 4);
		repeat (n) begin
			it = make_item($urandom_range(0, 1) ? OP_RECORD_PHASE : OP_GATED_WORK);
			if (it.operation == OP_GATED_WORK && $urandom_range(0, 1))
				it.work_usec = $urandom_range(0, 20000);
			send_event(it);
		end
		if ($urandom_range(0, 3) != 0)
			send_event(make_item(OP_FRAME_END));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) send_event(make_item(OP_WD_TICK));
	endtask

	task automatic play_frames(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target)
			play_frame();
	endtask

	task automatic test_directed();
		in_item_t it;
		it = make_item(OP_RECORD_PHASE);
		it.phase_color = 16'hFFFF;
		send_event(it);
		// Ticks with no heartbeat: the second reaches the limit and asks for the report.
		send_event(make_item(OP_WD_TICK));
		send_event(make_item(OP_WD_TICK));
		send_event(make_item(OP_WD_TICK));
		// The first frame start only stores the time; the second wraps around zero.
		send_frame_start(1'b0, 32'hFFFF_FFF0);
		send_frame_start(1'b1, 32'h0000_0010);
		it = make_item(OP_GATED_WORK);
		it.work_usec = 32'hFFFF_FFFF;
		send_event(it);
		it.work_usec = 32'h0;
		send_event(it);
		send_event(make_item(OP_WD_TICK));
		send_event(make_item(OP_FRAME_END));
		for (int k = 5; k < 8; k++)
			send_event(make_item(k[2:0]));
		send_frame_start(1'b0, 32'hFFFF_FFFF);
		send_frame_start(1'b1, 32'h0);
		it = make_item(OP_RECORD_PHASE);
		it.phase_color = 16'h0000;
		send_event(it);
		drain();
		write_reg(REG_OVERLAY_ENABLE, 16'd1);
		send_event(it);
		it.phase_color = 16'hFFFF;
		send_event(it);
		send_event(make_item(OP_FRAME_END));
		drain();
		write_reg(REG_DONE_PHASE_COLOR, 16'hFFFF);
		send_event(make_item(OP_FRAME_END));
		drain();
		write_reg(REG_DONE_PHASE_COLOR, 16'h0000);
		send_event(make_item(OP_FRAME_END));
		drain();
		write_reg(REG_OVERLAY_ENABLE, 16'd0);
	endtask

	task automatic test_config_extremes();
		in_item_t work;
		work = make_item(OP_GATED_WORK);
		// A zero stale limit paints on every tick that follows no heartbeat.
		write_reg(REG_STALE_TICK_LIMIT, 16'd0);
		repeat (3) send_event(make_item(OP_WD_TICK));
		drain();
		// Window lengths of zero and one restart the maxima on every interval.
		write_reg(REG_PERF_WINDOW_FRAMES, 16'd0);
		repeat (3) begin
			frame_clock = frame_clock + $urandom_range(1, 50000);
			send_frame_start(1'b0, frame_clock);
			work.work_usec = $urandom;
			send_event(work);
		end
		drain();
		write_reg(REG_PERF_WINDOW_FRAMES, 16'd1);
		repeat (3) begin
			frame_clock = frame_clock + $urandom_range(1, 50000);
			send_frame_start(1'b0, frame_clock);
			work.work_usec = $urandom;
			send_event(work);
		end
		drain();
		// A long run of stale ticks must hold the count at its ceiling.
		write_reg(REG_STALE_TICK_LIMIT, 16'd255);
		send_frame_start(1'b0, frame_clock);
		repeat (258) send_event(make_item(OP_WD_TICK));
		drain();
		write_reg(REG_PERF_WINDOW_FRAMES, 16'd1023);
		write_reg(REG_STALE_TICK_LIMIT, 16'd1);
		write_reg(REG_HUNG_FRAME_LIMIT, 16'd1000);
		play_frames(10);
		drain();
	endtask

	task automatic test_random_traffic();
		for (int s = 0; s < 6; s++) begin
			drain();
			write_reg(REG_OVERLAY_ENABLE, 16'(s % 2));
			write_reg(REG_PERF_WINDOW_FRAMES,
				16'((s == 0) ? 1 : (s == 1) ? 1023 : $urandom_range(1, 10)));
			write_reg(REG_STALE_TICK_LIMIT,
				16'((s == 2) ? 0 : (s == 3) ? 255 : $urandom_range(1, 4)));
			write_reg(REG_DONE_PHASE_COLOR, 16'($urandom_range(0, 65535)));
			write_reg(REG_HUNG_FRAME_LIMIT, 16'($urandom_range(24, 1023)));
			play_frames(12);
		end
		drain();
	endtask

	task automatic test_backpressure();
		// The receiver holds off while the sender offers items without gaps.
		rx_hold_req = 120;
		tx_gaps_on = 1'b0;
		play_frames(30);
		tx_gaps_on = 1'b1;
		drain();
	endtask

	task automatic test_fault();
		in_item_t it;
		allow_fault = 1'b1;
		write_reg(REG_STALE_TICK_LIMIT, 16'd1);
		write_reg(REG_OVERLAY_ENABLE, 16'd1);
		it = make_item(OP_WD_TICK);
		it.fault_pending = 1'b0;
		send_event(it);
		send_event(it);
		it.fault_pending = 1'b1;
		send_event(it);
		send_event(make_item(OP_WD_TICK));
		play_frames(12);
		drain();
	endtask

	task automatic test_hang();
		in_item_t it;
		write_reg(REG_HUNG_FRAME_LIMIT, 16'd1023);
		write_reg(REG_OVERLAY_ENABLE, 16'd0);
		write_reg(REG_PERF_WINDOW_FRAMES, 16'd1023);
		// The pending streak saturates, so a limit of 1023 never latches a hang.
		repeat (1030) begin
			frame_clock = frame_clock + $urandom_range(1, 40000);
			send_frame_start(1'b1, frame_clock);
		end
		drain();
		write_reg(REG_HUNG_FRAME_LIMIT, 16'd1022);
		frame_clock = frame_clock + $urandom_range(1, 40000);
		send_frame_start(1'b1, frame_clock);
		send_event(make_item(OP_RECORD_PHASE));
		send_event(make_item(OP_WD_TICK));
		send_event(make_item(OP_WD_TICK));
		drain();
		write_reg(REG_OVERLAY_ENABLE, 16'd1);
		send_event(make_item(OP_RECORD_PHASE));
		send_event(make_item(OP_FRAME_END));
		drain();
		write_reg(REG_HUNG_FRAME_LIMIT, 16'd0);
		play_frames(12);
		drain();
		// Writes past the register list must change nothing.
		for (int k = 5; k < 8; k++)
			write_reg(k[2:0], 16'($urandom_range(0, 65535)));
		play_frames(8);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		evt_if.valid = 1'b0;
		evt_if.data = '0;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		test_fault();
		test_hang();
		drain();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
